// ===== rtl/isub_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I-Sub similarity package
// Shared constants, payload structs, controller states and datapath commands.
// ---------------------------------------------------------------------------
package isub_pkg;

	// Capacity of each string and the widths that follow from it.
	localparam int MAX_LEN = 64;
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int WID     = 2 * CNT_W + 17;
	localparam int NUM_W   = WID + 16;
	localparam int DCNT_W  = $clog2(NUM_W + 1);

	// Fixed field widths.
	localparam int CP_W  = 21;
	localparam int SIM_W = 17;
	localparam int CC_W  = 7;

	// Command codes.
	localparam logic [1:0] CMD_FIRST  = 2'd0;
	localparam logic [1:0] CMD_SECOND = 2'd1;
	localparam logic [1:0] CMD_SCORE  = 2'd2;
	// The remaining code is accepted and changes nothing.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Characters used by normalization.
	localparam logic [CP_W-1:0] CH_UPPER_A = 21'h41;
	localparam logic [CP_W-1:0] CH_UPPER_Z = 21'h5A;
	localparam logic [CP_W-1:0] CH_CASE    = 21'h20;
	localparam logic [CP_W-1:0] CH_DOT     = 21'h2E;
	localparam logic [CP_W-1:0] CH_UNDER   = 21'h5F;
	localparam logic [CP_W-1:0] CH_SPACE   = 21'h20;

	localparam logic [SIM_W-1:0] SIM_ONE    = 17'h10000;
	localparam logic [2:0]       PREFIX_MAX = 3'd4;
	localparam int               MIN_KEEP   = 2;

	typedef struct packed {
		logic [1:0]      cmd;
		logic [CP_W-1:0] code_point;
	} isub_req_t;

	typedef struct packed {
		logic [SIM_W-1:0] similarity;
		logic [CC_W-1:0]  common_chars;
		logic             too_long;
	} isub_res_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_PF_INIT, OP_PF_RD, OP_PF_INC, OP_LOOP_INIT,
		OP_ITER_INIT, OP_J_INIT, OP_I_INC, OP_K_INIT, OP_SCAN_RD, OP_J_INC,
		OP_MATCH, OP_EXT_INC, OP_UPD, OP_CUTA_INIT, OP_CUTA_RD, OP_CUTA_WR,
		OP_CUTA_END, OP_CUTB_RD, OP_CUTB_WR, OP_CUTB_END, OP_ACC, OP_MUL1,
		OP_MUL2, OP_MUL3, OP_MUL4, OP_MUL5, OP_XSUM, OP_DIV, OP_EMIT
	} isub_op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_PF_INIT, S_PF_RD, S_PF_CMP, S_LOOP_INIT, S_LOOP_TEST,
		S_I_TEST, S_J_TEST, S_SCAN_RD, S_SCAN_CMP, S_EXT_RD, S_EXT_CMP,
		S_CUTA_RD, S_CUTA_WR, S_CUTB_RD, S_CUTB_WR, S_ACC, S_MUL1, S_MUL2,
		S_MUL3, S_MUL4, S_MUL5, S_XSUM, S_DIV, S_EMIT
	} isub_state_t;

	// Status returned by the datapath.
	typedef struct packed {
		logic eq;
		logic pf_more;
		logic any_empty;
		logic loop_go;
		logic i_go;
		logic j_go;
		logic scan_go;
		logic ext_go;
		logic cuta_go;
		logic cutb_go;
		logic div_done;
	} isub_stat_t;

endpackage

// ===== rtl/isub_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// I-Sub controller
// Sequences loading, prefix scan, substring removal, scoring and division.
// ---------------------------------------------------------------------------
module isub_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [1:0]           cmd,
	input  wire isub_pkg::isub_stat_t stat,
	output isub_pkg::isub_op_t        op,
	output logic                      busy
);

	isub_pkg::isub_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isub_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			isub_pkg::S_IDLE: begin
				if (start && cmd == isub_pkg::CMD_SCORE) state_d = isub_pkg::S_PF_INIT;
			end
			isub_pkg::S_PF_INIT:   state_d = isub_pkg::S_PF_RD;
			isub_pkg::S_PF_RD:
				state_d = stat.pf_more ? isub_pkg::S_PF_CMP : isub_pkg::S_LOOP_INIT;
			isub_pkg::S_PF_CMP:
				state_d = stat.eq ? isub_pkg::S_PF_RD : isub_pkg::S_LOOP_INIT;
			isub_pkg::S_LOOP_INIT:
				state_d = stat.any_empty ? isub_pkg::S_EMIT : isub_pkg::S_LOOP_TEST;
			isub_pkg::S_LOOP_TEST:
				state_d = stat.loop_go ? isub_pkg::S_I_TEST : isub_pkg::S_MUL1;
			isub_pkg::S_I_TEST:
				state_d = stat.i_go ? isub_pkg::S_J_TEST : isub_pkg::S_CUTA_RD;
			isub_pkg::S_J_TEST:
				state_d = stat.j_go ? isub_pkg::S_SCAN_RD : isub_pkg::S_I_TEST;
			isub_pkg::S_SCAN_RD:
				state_d = stat.scan_go ? isub_pkg::S_SCAN_CMP : isub_pkg::S_J_TEST;
			isub_pkg::S_SCAN_CMP:
				state_d = stat.eq ? isub_pkg::S_EXT_RD : isub_pkg::S_SCAN_RD;
			isub_pkg::S_EXT_RD:
				state_d = stat.ext_go ? isub_pkg::S_EXT_CMP : isub_pkg::S_J_TEST;
			isub_pkg::S_EXT_CMP:
				state_d = stat.eq ? isub_pkg::S_EXT_RD : isub_pkg::S_J_TEST;
			isub_pkg::S_CUTA_RD:
				state_d = stat.cuta_go ? isub_pkg::S_CUTA_WR : isub_pkg::S_CUTB_RD;
			isub_pkg::S_CUTA_WR:   state_d = isub_pkg::S_CUTA_RD;
			isub_pkg::S_CUTB_RD:
				state_d = stat.cutb_go ? isub_pkg::S_CUTB_WR : isub_pkg::S_ACC;
			isub_pkg::S_CUTB_WR:   state_d = isub_pkg::S_CUTB_RD;
			isub_pkg::S_ACC:       state_d = isub_pkg::S_LOOP_TEST;
			isub_pkg::S_MUL1:      state_d = isub_pkg::S_MUL2;
			isub_pkg::S_MUL2:      state_d = isub_pkg::S_MUL3;
			isub_pkg::S_MUL3:      state_d = isub_pkg::S_MUL4;
			isub_pkg::S_MUL4:      state_d = isub_pkg::S_MUL5;
			isub_pkg::S_MUL5:      state_d = isub_pkg::S_XSUM;
			isub_pkg::S_XSUM:      state_d = isub_pkg::S_DIV;
			isub_pkg::S_DIV:
				state_d = stat.div_done ? isub_pkg::S_EMIT : isub_pkg::S_DIV;
			isub_pkg::S_EMIT:      state_d = isub_pkg::S_IDLE;
			default:               state_d = isub_pkg::S_IDLE;
		endcase
	end

	// Datapath command for the current state.
	always_comb begin
		op = isub_pkg::OP_NONE;
		unique case (state_q)
			isub_pkg::S_IDLE: begin
				if (start && cmd != isub_pkg::CMD_SCORE) op = isub_pkg::OP_LOAD;
			end
			isub_pkg::S_PF_INIT:   op = isub_pkg::OP_PF_INIT;
			isub_pkg::S_PF_RD:     op = stat.pf_more ? isub_pkg::OP_PF_RD : isub_pkg::OP_NONE;
			isub_pkg::S_PF_CMP:    op = stat.eq ? isub_pkg::OP_PF_INC : isub_pkg::OP_NONE;
			isub_pkg::S_LOOP_INIT: op = isub_pkg::OP_LOOP_INIT;
			isub_pkg::S_LOOP_TEST:
				op = stat.loop_go ? isub_pkg::OP_ITER_INIT : isub_pkg::OP_NONE;
			isub_pkg::S_I_TEST:
				op = stat.i_go ? isub_pkg::OP_J_INIT : isub_pkg::OP_CUTA_INIT;
			isub_pkg::S_J_TEST:
				op = stat.j_go ? isub_pkg::OP_K_INIT : isub_pkg::OP_I_INC;
			isub_pkg::S_SCAN_RD:
				op = stat.scan_go ? isub_pkg::OP_SCAN_RD : isub_pkg::OP_NONE;
			isub_pkg::S_SCAN_CMP:
				op = stat.eq ? isub_pkg::OP_MATCH : isub_pkg::OP_J_INC;
			isub_pkg::S_EXT_RD:
				op = stat.ext_go ? isub_pkg::OP_SCAN_RD : isub_pkg::OP_UPD;
			isub_pkg::S_EXT_CMP:
				op = stat.eq ? isub_pkg::OP_EXT_INC : isub_pkg::OP_UPD;
			isub_pkg::S_CUTA_RD:
				op = stat.cuta_go ? isub_pkg::OP_CUTA_RD : isub_pkg::OP_CUTA_END;
			isub_pkg::S_CUTA_WR:   op = isub_pkg::OP_CUTA_WR;
			isub_pkg::S_CUTB_RD:
				op = stat.cutb_go ? isub_pkg::OP_CUTB_RD : isub_pkg::OP_CUTB_END;
			isub_pkg::S_CUTB_WR:   op = isub_pkg::OP_CUTB_WR;
			isub_pkg::S_ACC:       op = isub_pkg::OP_ACC;
			isub_pkg::S_MUL1:      op = isub_pkg::OP_MUL1;
			isub_pkg::S_MUL2:      op = isub_pkg::OP_MUL2;
			isub_pkg::S_MUL3:      op = isub_pkg::OP_MUL3;
			isub_pkg::S_MUL4:      op = isub_pkg::OP_MUL4;
			isub_pkg::S_MUL5:      op = isub_pkg::OP_MUL5;
			isub_pkg::S_XSUM:      op = isub_pkg::OP_XSUM;
			isub_pkg::S_DIV:       op = stat.div_done ? isub_pkg::OP_NONE : isub_pkg::OP_DIV;
			isub_pkg::S_EMIT:      op = isub_pkg::OP_EMIT;
			default:               op = isub_pkg::OP_NONE;
		endcase
	end

	// Loads are taken while idle; everything else holds the input off.
	assign busy = (state_q != isub_pkg::S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/isub_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// I-Sub datapath
// String stores, search indexes, score arithmetic and a restoring divider.
// ---------------------------------------------------------------------------
module isub_dpath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire isub_pkg::isub_op_t   op,
	input  wire isub_pkg::isub_req_t  request,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_wdata,
	output isub_pkg::isub_stat_t      stat,
	output isub_pkg::isub_res_t       result,
	output logic                      done
);

	localparam int CW = isub_pkg::CNT_W;
	localparam int AW = isub_pkg::ADDR_W;
	localparam int W  = isub_pkg::WID;
	localparam int NW = isub_pkg::NUM_W;

	logic [isub_pkg::CP_W-1:0] mem_a [isub_pkg::MAX_LEN];
	logic [isub_pkg::CP_W-1:0] mem_b [isub_pkg::MAX_LEN];
	logic [isub_pkg::CP_W-1:0] rd_a_q, rd_b_q;

	logic          normalize_q, overflow_q;
	logic [CW-1:0] cnt1_q, cnt2_q, l1_q, l2_q;
	logic [CW-1:0] i_q, j_q, k_q, p_q, best_q, prefix_q, common_q, x_q;
	logic [CW-1:0] s1_q, e1_q, s2_q, e2_q;

	logic [W-1:0]  p1_q, p2_q, p3_q, s_q, dd_q, u_q, v_q, w_q, z_q, den_q;
	logic [2:0]    pp_q;
	logic [W-1:0]  rem_q;
	logic [NW-1:0] num_q;
	logic [isub_pkg::DCNT_W-1:0] dcnt_q;

	logic [isub_pkg::CP_W-1:0] ch;
	logic                      ch_drop;
	logic                      wa_en, wb_en;
	logic [AW-1:0]             wa_addr, wb_addr, ra_addr, rb_addr;
	logic [isub_pkg::CP_W-1:0] wa_data, wb_data;
	logic [CW-1:0]             min_len, run_len, cut_a_len, cut_b_len;
	logic [W:0]                rem_t;
	logic [W-1:0]              x_sum;

	// Normalize an appended character.
	always_comb begin
		ch = request.code_point;
		if (normalize_q && ch >= isub_pkg::CH_UPPER_A && ch <= isub_pkg::CH_UPPER_Z) begin
			ch = ch + isub_pkg::CH_CASE;
		end
		ch_drop = normalize_q && (ch == isub_pkg::CH_DOT || ch == isub_pkg::CH_UNDER ||
			ch == isub_pkg::CH_SPACE);
	end

	assign cut_a_len = e1_q - s1_q;
	assign cut_b_len = e2_q - s2_q;
	assign run_len   = k_q - i_q;
	assign min_len   = (cnt1_q < cnt2_q) ? cnt1_q : cnt2_q;

	// Memory write ports: loads and compaction after a removal.
	always_comb begin
		wa_en   = 1'b0;
		wb_en   = 1'b0;
		wa_addr = cnt1_q[AW-1:0];
		wb_addr = cnt2_q[AW-1:0];
		wa_data = ch;
		wb_data = ch;
		if (op == isub_pkg::OP_LOAD && !ch_drop) begin
			wa_en = (request.cmd == isub_pkg::CMD_FIRST) &&
				(cnt1_q < CW'(isub_pkg::MAX_LEN));
			wb_en = (request.cmd == isub_pkg::CMD_SECOND) &&
				(cnt2_q < CW'(isub_pkg::MAX_LEN));
		end
		if (op == isub_pkg::OP_CUTA_WR) begin
			wa_en   = 1'b1;
			wa_addr = AW'(x_q - cut_a_len);
			wa_data = rd_a_q;
		end
		if (op == isub_pkg::OP_CUTB_WR) begin
			wb_en   = 1'b1;
			wb_addr = AW'(x_q - cut_b_len);
			wb_data = rd_b_q;
		end
	end

	// Memory read addresses.
	always_comb begin
		ra_addr = k_q[AW-1:0];
		rb_addr = j_q[AW-1:0];
		if (op == isub_pkg::OP_PF_RD) begin
			ra_addr = prefix_q[AW-1:0];
			rb_addr = prefix_q[AW-1:0];
		end
		if (op == isub_pkg::OP_CUTA_RD) ra_addr = x_q[AW-1:0];
		if (op == isub_pkg::OP_CUTB_RD) rb_addr = x_q[AW-1:0];
	end

	// String stores with registered reads.
	always_ff @(posedge clk) begin
		if (wa_en) mem_a[wa_addr] <= wa_data;
		if (wb_en) mem_b[wb_addr] <= wb_data;
		rd_a_q <= mem_a[ra_addr];
		rd_b_q <= mem_b[rb_addr];
	end

	// Control registers: counts, flags and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normalize_q <= 1'b0;
			overflow_q  <= 1'b0;
			cnt1_q      <= '0;
			cnt2_q      <= '0;
			done        <= 1'b0;
		end else begin
			done <= (op == isub_pkg::OP_EMIT);
			if (cfg_we) normalize_q <= cfg_wdata;
			if (wa_en && op == isub_pkg::OP_LOAD) cnt1_q <= cnt1_q + 1'b1;
			if (wb_en && op == isub_pkg::OP_LOAD) cnt2_q <= cnt2_q + 1'b1;
			if (op == isub_pkg::OP_LOAD && !ch_drop &&
				((request.cmd == isub_pkg::CMD_FIRST &&
				cnt1_q >= CW'(isub_pkg::MAX_LEN)) ||
				(request.cmd == isub_pkg::CMD_SECOND &&
				cnt2_q >= CW'(isub_pkg::MAX_LEN)))) begin
				overflow_q <= 1'b1;
			end
			if (op == isub_pkg::OP_EMIT) begin
				cnt1_q     <= '0;
				cnt2_q     <= '0;
				overflow_q <= 1'b0;
			end
		end
	end

	// Search indexes and substring removal.
	always_ff @(posedge clk) begin
		unique case (op)
			isub_pkg::OP_PF_INIT: begin
				l1_q     <= cnt1_q;
				l2_q     <= cnt2_q;
				prefix_q <= '0;
			end
			isub_pkg::OP_PF_INC:   prefix_q <= prefix_q + 1'b1;
			isub_pkg::OP_LOOP_INIT: begin
				common_q <= '0;
				best_q   <= CW'(isub_pkg::MIN_KEEP);
			end
			isub_pkg::OP_ITER_INIT: begin
				best_q <= '0;
				i_q    <= '0;
				s1_q   <= '0;
				e1_q   <= '0;
				s2_q   <= '0;
				e2_q   <= '0;
			end
			isub_pkg::OP_J_INIT:   j_q <= '0;
			isub_pkg::OP_I_INC:    i_q <= i_q + 1'b1;
			isub_pkg::OP_K_INIT:   k_q <= i_q;
			isub_pkg::OP_J_INC:    j_q <= j_q + 1'b1;
			isub_pkg::OP_MATCH: begin
				p_q <= j_q;
				j_q <= j_q + 1'b1;
				k_q <= k_q + 1'b1;
			end
			isub_pkg::OP_EXT_INC: begin
				j_q <= j_q + 1'b1;
				k_q <= k_q + 1'b1;
			end
			isub_pkg::OP_UPD: begin
				if (run_len > best_q) begin
					best_q <= run_len;
					s1_q   <= i_q;
					e1_q   <= k_q;
					s2_q   <= p_q;
					e2_q   <= j_q;
				end
			end
			isub_pkg::OP_CUTA_INIT: x_q <= e1_q;
			isub_pkg::OP_CUTA_WR:   x_q <= x_q + 1'b1;
			isub_pkg::OP_CUTA_END: begin
				l1_q <= l1_q - cut_a_len;
				x_q  <= e2_q;
			end
			isub_pkg::OP_CUTB_WR:   x_q <= x_q + 1'b1;
			isub_pkg::OP_CUTB_END:  l2_q <= l2_q - cut_b_len;
			isub_pkg::OP_ACC: begin
				if (best_q > CW'(isub_pkg::MIN_KEEP)) common_q <= common_q + best_q;
				else best_q <= '0;
			end
			default: ;
		endcase
	end

	// Numerator sum; small true magnitudes make the wrap-around exact.
	assign x_sum = (u_q << 3) + (u_q << 1) + (v_q << 4) + (v_q << 2)
		- (w_q << 3) - (w_q << 1) + z_q;

	// One restoring division step.
	assign rem_t = {rem_q, num_q[NW-1]};

	// Score arithmetic and divider.
	always_ff @(posedge clk) begin
		unique case (op)
			isub_pkg::OP_MUL1: begin
				p1_q <= W'(cnt1_q) * W'(cnt2_q);
				p2_q <= W'(common_q) * W'(common_q);
				s_q  <= W'(cnt1_q) + W'(cnt2_q);
				pp_q <= (prefix_q > CW'(isub_pkg::PREFIX_MAX)) ? isub_pkg::PREFIX_MAX :
					prefix_q[2:0];
			end
			isub_pkg::OP_MUL2: begin
				dd_q <= (p1_q << 2) + p1_q - (p2_q << 1);
				p3_q <= W'(cnt1_q - common_q) * W'(cnt2_q - common_q);
			end
			isub_pkg::OP_MUL3: begin
				u_q  <= s_q * dd_q;
				v_q  <= W'(common_q) * dd_q;
				p3_q <= (p3_q << 2) + p3_q;
			end
			isub_pkg::OP_MUL4: begin
				w_q   <= s_q * p3_q;
				z_q   <= W'(pp_q) * (s_q - (W'(common_q) << 1));
				den_q <= (u_q << 4) + (u_q << 2);
			end
			isub_pkg::OP_MUL5:     z_q <= z_q * dd_q;
			isub_pkg::OP_XSUM: begin
				rem_q  <= '0;
				dcnt_q <= isub_pkg::DCNT_W'(NW);
				num_q  <= x_sum[W-1] ? '0 : {x_sum, 16'h0000};
			end
			isub_pkg::OP_DIV: begin
				dcnt_q <= dcnt_q - 1'b1;
				if (rem_t >= {1'b0, den_q}) begin
					rem_q <= W'(rem_t - {1'b0, den_q});
					num_q <= {num_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= rem_t[W-1:0];
					num_q <= {num_q[NW-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (op == isub_pkg::OP_EMIT) begin
			result.too_long <= overflow_q;
			if (cnt1_q == '0 && cnt2_q == '0) begin
				result.similarity   <= isub_pkg::SIM_ONE;
				result.common_chars <= '0;
			end else if (cnt1_q == '0 || cnt2_q == '0) begin
				result.similarity   <= '0;
				result.common_chars <= '0;
			end else begin
				result.similarity   <= (num_q > NW'(isub_pkg::SIM_ONE)) ?
					isub_pkg::SIM_ONE : num_q[isub_pkg::SIM_W-1:0];
				result.common_chars <= isub_pkg::CC_W'(common_q);
			end
		end
	end

	// Status to the controller.
	always_comb begin
		stat.eq        = (rd_a_q == rd_b_q);
		stat.pf_more   = (prefix_q < min_len);
		stat.any_empty = (cnt1_q == '0) || (cnt2_q == '0);
		stat.loop_go   = (l1_q != '0) && (l2_q != '0) && (best_q != '0);
		stat.i_go      = (i_q < l1_q) && ((l1_q - i_q) > best_q);
		stat.j_go      = ((l2_q - j_q) > best_q);
		stat.scan_go   = (j_q < l2_q);
		stat.ext_go    = (j_q < l2_q) && (k_q < l1_q);
		stat.cuta_go   = (x_q < l1_q);
		stat.cutb_go   = (x_q < l2_q);
		stat.div_done  = (dcnt_q == '0);
	end

endmodule
`default_nettype wire

// ===== rtl/isub_string_similarity_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Append items are taken one per cycle and may follow back to back; busy stays low.
// A score item holds busy high through the prefix scan, the substring search and
// compaction, the score arithmetic (MUL1 to MUL5 and XSUM), the division and the
// EMIT state.
// The result strobe done rises in the first idle cycle; the receiver cannot stall.
// Reset clears counts, flags, normalize and the controller; string stores are not cleared.
// ---------------------------------------------------------------------------
// I-Sub string similarity core
// Loads two code-point strings and scores their I-Sub similarity.
// ---------------------------------------------------------------------------
module isub_string_similarity_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire isub_pkg::isub_req_t request,
	output logic                     busy,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	output isub_pkg::isub_res_t      result,
	output logic                     done
);

	isub_pkg::isub_op_t   op;
	isub_pkg::isub_stat_t stat;

	// Sequencer.
	isub_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (request.cmd),
		.stat   (stat),
		.op     (op),
		.busy   (busy)
	);

	// Stores and arithmetic.
	isub_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.request   (request),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.result    (result),
		.done      (done)
	);

endmodule
`default_nettype wire
